FILE: rtl/skf_pkg.sv
// Shared constants, types and state encoding for the scalar Kalman filter.
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

    // Input sample field and the number of its low bits that carry the value.
    localparam int SAMPLE_BITS  = 16;
    localparam int SAMPLE_WIDTH = 16;

    // Q16.16 word, gain and divider sizes.
    localparam int WORD_BITS    = 32;
    localparam int GAIN_BITS    = 17;
    localparam int DEN_BITS     = WORD_BITS + 1;
    localparam int REM_BITS     = WORD_BITS + 2;
    localparam int DIV_STEPS    = GAIN_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Shared multiplier operand and product sizes.
    localparam int MUL_A_BITS   = WORD_BITS + 2;
    localparam int MUL_B_BITS   = GAIN_BITS + 1;
    localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;

    localparam logic [GAIN_BITS-1:0] Q_ONE      = 17'h1_0000;
    localparam logic [WORD_BITS-1:0] NOISE_INIT = 32'h0001_0000;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MEASUREMENT_NOISE = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_DEN,
        ST_DIV_GO,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_COV,
        ST_COV,
        ST_OUT
    } skf_state_t;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic                 start;
        logic [WORD_BITS-1:0] pred;
        logic [DEN_BITS-1:0]  den;
    } skf_div_req_t;

endpackage

`default_nettype wire

FILE: rtl/skf_div.sv
// Restoring divider that forms the Kalman gain one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module skf_div
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire skf_pkg::skf_div_req_t                req,
    output logic                                      done,
    output logic [skf_pkg::GAIN_BITS-1:0]             quotient
);

    logic [skf_pkg::REM_BITS-1:0]     rem_reg, rem_next;
    logic [skf_pkg::GAIN_BITS-1:0]    quo_reg, quo_next;
    logic [skf_pkg::DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [skf_pkg::DEN_BITS-1:0]     den_reg, den_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [skf_pkg::REM_BITS-1:0]     den_ext;
    logic [skf_pkg::REM_BITS-1:0]     diff;
    logic                             fits;

    // One compare and subtract per cycle; the remainder is kept pre-shifted.
    assign den_ext = {1'b0, den_reg};
    assign fits    = rem_reg >= den_ext;
    assign diff    = fits ? (rem_reg - den_ext) : rem_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {2'b00, req.pred};
            den_next  = req.den;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = {diff[skf_pkg::REM_BITS-2:0], 1'b0};
            quo_next = {quo_reg[skf_pkg::GAIN_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == skf_pkg::DIV_CNT_BITS'(skf_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/skf_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module skf_mul
(
    input  wire logic                                  clk,
    input  wire logic signed [skf_pkg::MUL_A_BITS-1:0] a,
    input  wire logic signed [skf_pkg::MUL_B_BITS-1:0] b,
    output logic signed [skf_pkg::MUL_P_BITS-1:0]      product
);

    logic signed [skf_pkg::MUL_P_BITS-1:0] prod_reg, prod_next;

    // Both operands are sign-extended to the product width before the multiply.
    assign prod_next = skf_pkg::MUL_P_BITS'(a) * skf_pkg::MUL_P_BITS'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

`default_nettype wire

FILE: rtl/scalar_kalman_filter.sv
// Each input transfer passes through prediction, denominator, the 17-step gain division,
// two passes through the shared multiplier and the covariance update before the result
// is offered on the output. A new sample is accepted only after that result is loaded into
// the output register, where it waits while the next sample is accepted.
// Reset (rst_n low, asynchronous) clears estimate and covariance to zero and sets
// both noise registers to 1.0 in Q16.16.
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_filter
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Input samples. s_tdata: [15:0] sample (signed integer).
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [15:0]                           s_tdata,
    // Filtered estimates. m_tdata: [31:0] estimate (signed Q16.16).
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [31:0]                                m_tdata,
    // Configuration writes.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [skf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [31:0]                           cfg_data
);

    localparam logic signed [35:0] EST_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] EST_MIN = 36'shF_8000_0000;

    skf_pkg::skf_state_t state_reg, state_next;

    // Filter state and noise registers.
    logic        [31:0] q_reg, q_next;
    logic        [31:0] r_reg, r_next;
    logic signed [31:0] est_reg, est_next;
    logic        [31:0] cov_reg, cov_next;

    // Per-sample working registers.
    logic signed [skf_pkg::SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic        [31:0]                     pred_reg, pred_next;
    logic        [skf_pkg::DEN_BITS-1:0]    den_reg, den_next;
    logic signed [33:0]                     innov_reg, innov_next;
    logic        [skf_pkg::GAIN_BITS-1:0]   gain_reg, gain_next;

    // Output register.
    logic        [31:0] out_reg, out_next;
    logic               valid_reg, valid_next;

    // Control from the sequencer.
    logic               in_xfer;
    logic               mul_sel_cov;
    logic               out_load;
    skf_pkg::skf_div_req_t div_req;

    // Shared units.
    logic                                   div_done;
    logic [skf_pkg::GAIN_BITS-1:0]          div_quotient;
    logic signed [skf_pkg::MUL_A_BITS-1:0]  mul_a;
    logic signed [skf_pkg::MUL_B_BITS-1:0]  mul_b;
    logic signed [skf_pkg::MUL_P_BITS-1:0]  mul_p;

    // Datapath helpers.
    logic signed [skf_pkg::SAMPLE_BITS-1:0] sample_ext;
    logic        [32:0]                     pred_sum;
    logic signed [31:0]                     sample_q;
    logic signed [35:0]                     delta;
    logic signed [35:0]                     est_sum;

    // Only the low SAMPLE_WIDTH bits of a sample count; they are sign-extended.
    assign sample_ext = $signed(s_tdata[skf_pkg::SAMPLE_WIDTH-1:0]);

    // The divider sees the saturated prediction and the 33-bit denominator.
    assign div_req.start = (state_reg == skf_pkg::ST_DIV_GO);
    assign div_req.pred  = pred_reg;
    assign div_req.den   = den_reg;

    skf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // The multiplier first forms gain times innovation, then (1 - gain) times the
    // predicted covariance.
    always_comb
    begin
        if (mul_sel_cov)
        begin
            mul_a = {2'b00, pred_reg};
            mul_b = {1'b0, skf_pkg::Q_ONE - gain_reg};
        end
        else
        begin
            mul_a = innov_reg;
            mul_b = {1'b0, gain_reg};
        end
    end

    skf_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = skf_pkg::ST_PRED;
                end
            end
            skf_pkg::ST_PRED:    state_next = skf_pkg::ST_DEN;
            skf_pkg::ST_DEN:     state_next = skf_pkg::ST_DIV_GO;
            skf_pkg::ST_DIV_GO:  state_next = skf_pkg::ST_DIV;
            skf_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = skf_pkg::ST_MUL_EST;
                end
            end
            skf_pkg::ST_MUL_EST: state_next = skf_pkg::ST_MUL_COV;
            skf_pkg::ST_MUL_COV: state_next = skf_pkg::ST_COV;
            skf_pkg::ST_COV:     state_next = skf_pkg::ST_OUT;
            skf_pkg::ST_OUT:
            begin
                if (!valid_reg || m_tready)
                begin
                    state_next = skf_pkg::ST_IDLE;
                end
            end
            default:             state_next = skf_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready    = (state_reg == skf_pkg::ST_IDLE);
        mul_sel_cov = (state_reg == skf_pkg::ST_MUL_COV);
        out_load    = (state_reg == skf_pkg::ST_OUT) && (!valid_reg || m_tready);
    end

    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign pred_sum = {1'b0, cov_reg} + {1'b0, q_reg};
    assign sample_q = {sample_reg, 16'h0000};
    assign delta    = mul_p[skf_pkg::MUL_P_BITS-1:16];
    assign est_sum  = {{4{est_reg[31]}}, est_reg} + delta;

    // Datapath register updates.
    always_comb
    begin
        q_next      = q_reg;
        r_next      = r_reg;
        est_next    = est_reg;
        cov_next    = cov_reg;
        sample_next = sample_reg;
        pred_next   = pred_reg;
        den_next    = den_reg;
        innov_next  = innov_reg;
        gain_next   = gain_reg;
        out_next    = out_reg;
        valid_next  = valid_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == skf_pkg::REG_PROCESS_NOISE)
            begin
                q_next = cfg_data;
            end
            else if (cfg_index == skf_pkg::REG_MEASUREMENT_NOISE)
            begin
                r_next = cfg_data;
            end
        end

        if (in_xfer)
        begin
            sample_next = sample_ext;
        end

        // Prediction saturates at the largest covariance.
        if (state_reg == skf_pkg::ST_PRED)
        begin
            pred_next = pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];
        end

        if (state_reg == skf_pkg::ST_DEN)
        begin
            den_next   = {1'b0, pred_reg} + {1'b0, r_reg};
            innov_next = {{2{sample_q[31]}}, sample_q} - {{2{est_reg[31]}}, est_reg};
        end

        // A zero denominator means both terms are zero; the gain is then one.
        if ((state_reg == skf_pkg::ST_DIV) && div_done)
        begin
            gain_next = (den_reg == '0) ? skf_pkg::Q_ONE : div_quotient;
        end

        // The product of gain and innovation is ready here; floor by shifting.
        if (state_reg == skf_pkg::ST_MUL_COV)
        begin
            if (est_sum > EST_MAX)
            begin
                est_next = EST_MAX[31:0];
            end
            else if (est_sum < EST_MIN)
            begin
                est_next = EST_MIN[31:0];
            end
            else
            begin
                est_next = est_sum[31:0];
            end
        end

        if (state_reg == skf_pkg::ST_COV)
        begin
            cov_next = mul_p[47:16];
        end

        if (m_tready)
        begin
            valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_next   = est_reg;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skf_pkg::ST_IDLE;
            q_reg     <= skf_pkg::NOISE_INIT;
            r_reg     <= skf_pkg::NOISE_INIT;
            est_reg   <= '0;
            cov_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            q_reg     <= q_next;
            r_reg     <= r_next;
            est_reg   <= est_next;
            cov_reg   <= cov_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        pred_reg   <= pred_next;
        den_reg    <= den_next;
        innov_reg  <= innov_next;
        gain_reg   <= gain_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    // The divider only reports completion while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == skf_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    // The gain never exceeds one when it is used.
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == skf_pkg::ST_MUL_EST) |-> (gain_reg <= skf_pkg::Q_ONE))
        else $error("gain above one");

    // The covariance product always fits the 32-bit covariance after scaling.
    a_cov_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == skf_pkg::ST_COV) |-> (mul_p[skf_pkg::MUL_P_BITS-1:48] == '0))
        else $error("covariance product overflow");

    // A new result is loaded only when the output register is free or draining.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tdata == $past(m_tdata)))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
